// ===== hw/rtl/tpe_pkg.sv =====
package tpe_pkg;

  localparam int MAX_DEGREE = 4;
  localparam int COEF_DEPTH = 35;
  localparam int IDX_W      = $clog2(COEF_DEPTH);
  localparam int PW_W       = $clog2(MAX_DEGREE + 1);
  localparam int EXP_W      = 3;
  localparam int DEG_W      = 3;
  localparam int Q_W        = 32;
  localparam int FRAC       = 16;
  localparam int OUT_W      = 48;
  localparam int FAC_W      = 4;
  localparam int N_OUT      = 10;
  localparam int CNT_W      = 8;

  // Result slots
  localparam int R_VAL = 0;
  localparam int R_GX  = 1;
  localparam int R_GY  = 2;
  localparam int R_GZ  = 3;
  localparam int R_HXX = 4;
  localparam int R_HYY = 5;
  localparam int R_HZZ = 6;
  localparam int R_HXY = 7;
  localparam int R_HXZ = 8;
  localparam int R_HYZ = 9;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [OUT_W-1:0] acc_t;
  typedef logic [EXP_W-1:0]        exp_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [DEG_W-1:0]        deg_t;
  typedef q_t                      pow_arr_t [MAX_DEGREE+1];
  typedef acc_t                    acc_arr_t [N_OUT];

  localparam q_t Q_ONE = q_t'(1) <<< FRAC;

  // One term in flight: valid flag and its exponents
  typedef struct packed {
    logic v;
    exp_t ex;
    exp_t ey;
    exp_t ez;
  } term_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic logic [CNT_W-1:0] term_count(input deg_t d);
    logic [CNT_W-1:0] r;
    case (d)
      3'd0:    r = 8'd1;
      3'd1:    r = 8'd4;
      3'd2:    r = 8'd10;
      3'd3:    r = 8'd20;
      default: r = 8'd35;
    endcase
    return r;
  endfunction

  function automatic idx_t term_index(input exp_t i, input exp_t j, input exp_t k);
    logic [CNT_W-1:0] s;
    logic [CNT_W-1:0] t;
    logic [CNT_W-1:0] tri_n;
    s     = CNT_W'(i) + CNT_W'(j) + CNT_W'(k);
    t     = CNT_W'(i) + CNT_W'(j);
    tri_n = CNT_W'(((t + 8'd1) * (t + 8'd2)) >> 1);
    return IDX_W'(term_count(s[DEG_W-1:0]) - tri_n + CNT_W'(j));
  endfunction

  // Fixed exponent triple of each term index, {x, y, z}
  function automatic logic [3*EXP_W-1:0] exp_of(input idx_t n);
    logic [3*EXP_W-1:0] r;
    r = '0;
    for (int s = 0; s <= MAX_DEGREE; s++) begin
      for (int i = 0; i <= s; i++) begin
        for (int j = 0; j <= s - i; j++) begin
          if (term_index(EXP_W'(i), EXP_W'(j), EXP_W'(s - i - j)) == n) begin
            r = {EXP_W'(i), EXP_W'(j), EXP_W'(s - i - j)};
          end
        end
      end
    end
    return r;
  endfunction

  // Q16.16 product, floored and saturated to 32 bits
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [2*Q_W-1:0] p;
    q_t r;
    p = a * b;
    if (!p[2*Q_W-1] && (|p[2*Q_W-2:Q_W+FRAC-1])) begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end else if (p[2*Q_W-1] && !(&p[2*Q_W-2:Q_W+FRAC-1])) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = p[Q_W+FRAC-1:FRAC];
    end
    return r;
  endfunction

  function automatic q_t pow_pick(input pow_arr_t pw, input exp_t e, input exp_t lower);
    q_t r;
    r = '0;
    if (e >= lower && (e - lower) <= EXP_W'(MAX_DEGREE)) begin
      r = pw[PW_W'(e - lower)];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/trivariate_poly_eval_grad_hess.sv =====
// Trivariate polynomial evaluator with gradient and Hessian.
//
// Input channel (in_valid/in_ready): in_mode 0 writes in_coef_value at the
// term given by in_exp_x/y/z; in_mode 1 evaluates at in_point_x/y/z (Q16.16).
// Result channel (out_valid/out_ready): one result per item, ten Q32.16 sums
// and out_write_error, which flags a write whose exponent sum exceeds the
// degree in use (that write is dropped).
// Configuration channel (cfg_valid/cfg_ready): cfg_poly_degree, always ready.
// Sequence: a write loads its result into the output register once that is
// free. An evaluate first computes the coordinate powers, then reads one
// term per cycle (1, 4, 10, 20 or 35 for degree 0..4) from the coefficient
// memory, then drains the multiply pipeline and loads the output. One item
// is in flight at a time and the next is taken the cycle after the load.
// Reset: synchronous, active low; coefficients read as zero and the degree
// is zero. No clearing pass is needed. A stalled receiver holds the result
// register; the block takes one more item and holds its result until the
// register frees.
module trivariate_poly_eval_grad_hess (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_poly_degree,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_mode,
  input  logic [2:0]                 in_exp_x,
  input  logic [2:0]                 in_exp_y,
  input  logic [2:0]                 in_exp_z,
  input  logic signed [31:0]         in_coef_value,
  input  logic signed [31:0]         in_point_x,
  input  logic signed [31:0]         in_point_y,
  input  logic signed [31:0]         in_point_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [47:0]         out_value,
  output logic signed [47:0]         out_grad_x,
  output logic signed [47:0]         out_grad_y,
  output logic signed [47:0]         out_grad_z,
  output logic signed [47:0]         out_hess_xx,
  output logic signed [47:0]         out_hess_yy,
  output logic signed [47:0]         out_hess_zz,
  output logic signed [47:0]         out_hess_xy,
  output logic signed [47:0]         out_hess_xz,
  output logic signed [47:0]         out_hess_yz,
  output logic                       out_write_error
);
  import tpe_pkg::*;

  state_t   state_r, state_nxt;
  deg_t     deg_r, eff_deg;
  logic     mode_r;
  logic     err_r;
  idx_t     n_r;
  idx_t     last_r;
  term_t    issue_r;

  logic     pow_start, pipe_clear, rd_en, mem_we, load_out;
  logic     pow_busy, pipe_busy;
  logic     wr_err;
  idx_t     wr_idx;
  logic [4:0] exp_sum;

  q_t       coef_rd;
  pow_arr_t xp, yp, zp;
  acc_arr_t acc;

  acc_t     out_r [N_OUT];
  logic     out_err_r;
  logic     out_valid_r;

  // Degree codes above the maximum act as the maximum
  assign eff_deg = (deg_r > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_r;

  assign exp_sum = 5'(in_exp_x) + 5'(in_exp_y) + 5'(in_exp_z);
  assign wr_err  = exp_sum > 5'(eff_deg);
  assign wr_idx  = term_index(in_exp_x, in_exp_y, in_exp_z);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= '0;
    end else if (cfg_valid) begin
      deg_r <= cfg_poly_degree;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    pow_start  = 1'b0;
    pipe_clear = 1'b0;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            pow_start  = 1'b1;
            pipe_clear = 1'b1;
            state_nxt  = ST_POW;
          end else begin
            mem_we    = !wr_err;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_POW: begin
        if (!pow_busy) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rd_en = 1'b1;
        if (n_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!issue_r.v && !pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold item kind, write flag and term range for the item in flight
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mode_r <= in_mode;
      err_r  <= wr_err;
      last_r <= IDX_W'(term_count(eff_deg) - CNT_W'(1));
    end
    if (pow_start) begin
      n_r <= '0;
    end else if (rd_en) begin
      n_r <= n_r + IDX_W'(1);
    end
    {issue_r.ex, issue_r.ey, issue_r.ez} <= exp_of(n_r);
  end

  // Term tag travels with the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r.v <= 1'b0;
    end else begin
      issue_r.v <= rd_en;
    end
  end

  tpe_coef_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (wr_idx),
    .wr_data (in_coef_value),
    .rd_en   (rd_en),
    .rd_addr (n_r),
    .rd_data (coef_rd)
  );

  tpe_pow_unit u_pow (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pow_start),
    .px    (in_point_x),
    .py    (in_point_y),
    .pz    (in_point_z),
    .xp    (xp),
    .yp    (yp),
    .zp    (zp),
    .busy  (pow_busy)
  );

  tpe_term_pipe u_pipe (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (pipe_clear),
    .term  (issue_r),
    .coef  (coef_rd),
    .xp    (xp),
    .yp    (yp),
    .zp    (zp),
    .acc   (acc),
    .busy  (pipe_busy)
  );

  // Output register: a write reports only its flag, an evaluate only sums
  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int m = 0; m < N_OUT; m++) begin
        out_r[m] <= mode_r ? acc[m] : '0;
      end
      out_err_r <= mode_r ? 1'b0 : err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_error = out_err_r;
  assign out_value       = out_r[R_VAL];
  assign out_grad_x      = out_r[R_GX];
  assign out_grad_y      = out_r[R_GY];
  assign out_grad_z      = out_r[R_GZ];
  assign out_hess_xx     = out_r[R_HXX];
  assign out_hess_yy     = out_r[R_HYY];
  assign out_hess_zz     = out_r[R_HZZ];
  assign out_hess_xy     = out_r[R_HXY];
  assign out_hess_xz     = out_r[R_HXZ];
  assign out_hess_yz     = out_r[R_HYZ];

endmodule

// ===== hw/rtl/tpe_coef_mem.sv =====
module tpe_coef_mem (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  tpe_pkg::idx_t wr_addr,
  input  tpe_pkg::q_t   wr_data,
  input  logic          rd_en,
  input  tpe_pkg::idx_t rd_addr,
  output tpe_pkg::q_t   rd_data
);
  import tpe_pkg::*;

  q_t   mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0] vld_r;
  q_t   rd_q_r;
  logic rd_v_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_v_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_v_r ? rd_q_r : '0;

endmodule

// ===== hw/rtl/tpe_pow_unit.sv =====
module tpe_pow_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tpe_pkg::q_t       px,
  input  tpe_pkg::q_t       py,
  input  tpe_pkg::q_t       pz,
  output tpe_pkg::pow_arr_t xp,
  output tpe_pkg::pow_arr_t yp,
  output tpe_pkg::pow_arr_t zp,
  output logic              busy
);
  import tpe_pkg::*;

  logic            busy_r;
  logic [PW_W-1:0] cnt_r;
  q_t              px_r, py_r, pz_r;
  q_t              lx_r, ly_r, lz_r;
  pow_arr_t        xp_r, yp_r, zp_r;
  q_t              nx, ny, nz;

  assign nx = qmul(lx_r, px_r);
  assign ny = qmul(ly_r, py_r);
  assign nz = qmul(lz_r, pz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= PW_W'(1);
    end else if (busy_r) begin
      if (cnt_r == PW_W'(MAX_DEGREE)) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + PW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px_r    <= px;
      py_r    <= py;
      pz_r    <= pz;
      lx_r    <= Q_ONE;
      ly_r    <= Q_ONE;
      lz_r    <= Q_ONE;
      xp_r[0] <= Q_ONE;
      yp_r[0] <= Q_ONE;
      zp_r[0] <= Q_ONE;
    end else if (busy_r) begin
      lx_r        <= nx;
      ly_r        <= ny;
      lz_r        <= nz;
      xp_r[cnt_r] <= nx;
      yp_r[cnt_r] <= ny;
      zp_r[cnt_r] <= nz;
    end
  end

  assign xp   = xp_r;
  assign yp   = yp_r;
  assign zp   = zp_r;
  assign busy = busy_r;

endmodule

// ===== hw/rtl/tpe_term_pipe.sv =====
module tpe_term_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  tpe_pkg::term_t    term,
  input  tpe_pkg::q_t       coef,
  input  tpe_pkg::pow_arr_t xp,
  input  tpe_pkg::pow_arr_t yp,
  input  tpe_pkg::pow_arr_t zp,
  output tpe_pkg::acc_arr_t acc,
  output logic              busy
);
  import tpe_pkg::*;

  term_t    s1_r, s2_r, s3_r;
  q_t       cx_r  [3];
  q_t       pxy_r [6];
  q_t       t_r   [N_OUT];
  acc_arr_t acc_r;
  logic [FAC_W-1:0] fac [N_OUT];

  // x stage: no lowering, once, twice
  always_ff @(posedge clk) begin
    cx_r[0] <= qmul(coef, pow_pick(xp, term.ex, 3'd0));
    cx_r[1] <= qmul(coef, pow_pick(xp, term.ex, 3'd1));
    cx_r[2] <= qmul(coef, pow_pick(xp, term.ex, 3'd2));
    s1_r.ex <= term.ex;
    s1_r.ey <= term.ey;
    s1_r.ez <= term.ez;
  end

  // xy stage: pairs 00, 10, 01, 20, 02, 11
  always_ff @(posedge clk) begin
    pxy_r[0] <= qmul(cx_r[0], pow_pick(yp, s1_r.ey, 3'd0));
    pxy_r[1] <= qmul(cx_r[1], pow_pick(yp, s1_r.ey, 3'd0));
    pxy_r[2] <= qmul(cx_r[0], pow_pick(yp, s1_r.ey, 3'd1));
    pxy_r[3] <= qmul(cx_r[2], pow_pick(yp, s1_r.ey, 3'd0));
    pxy_r[4] <= qmul(cx_r[0], pow_pick(yp, s1_r.ey, 3'd2));
    pxy_r[5] <= qmul(cx_r[1], pow_pick(yp, s1_r.ey, 3'd1));
    s2_r.ex  <= s1_r.ex;
    s2_r.ey  <= s1_r.ey;
    s2_r.ez  <= s1_r.ez;
  end

  // z stage: one product per result slot
  always_ff @(posedge clk) begin
    t_r[R_VAL] <= qmul(pxy_r[0], pow_pick(zp, s2_r.ez, 3'd0));
    t_r[R_GX]  <= qmul(pxy_r[1], pow_pick(zp, s2_r.ez, 3'd0));
    t_r[R_GY]  <= qmul(pxy_r[2], pow_pick(zp, s2_r.ez, 3'd0));
    t_r[R_GZ]  <= qmul(pxy_r[0], pow_pick(zp, s2_r.ez, 3'd1));
    t_r[R_HXX] <= qmul(pxy_r[3], pow_pick(zp, s2_r.ez, 3'd0));
    t_r[R_HYY] <= qmul(pxy_r[4], pow_pick(zp, s2_r.ez, 3'd0));
    t_r[R_HZZ] <= qmul(pxy_r[0], pow_pick(zp, s2_r.ez, 3'd2));
    t_r[R_HXY] <= qmul(pxy_r[5], pow_pick(zp, s2_r.ez, 3'd0));
    t_r[R_HXZ] <= qmul(pxy_r[1], pow_pick(zp, s2_r.ez, 3'd1));
    t_r[R_HYZ] <= qmul(pxy_r[2], pow_pick(zp, s2_r.ez, 3'd1));
    s3_r.ex    <= s2_r.ex;
    s3_r.ey    <= s2_r.ey;
    s3_r.ez    <= s2_r.ez;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.v <= 1'b0;
      s2_r.v <= 1'b0;
      s3_r.v <= 1'b0;
    end else begin
      s1_r.v <= term.v;
      s2_r.v <= s1_r.v;
      s3_r.v <= s2_r.v;
    end
  end

  // Integer factors; a factor of zero drops a lowering that does not exist
  always_comb begin
    logic [7:0] a, b, e;
    a = 8'(s3_r.ex);
    b = 8'(s3_r.ey);
    e = 8'(s3_r.ez);
    fac[R_VAL] = FAC_W'(1);
    fac[R_GX]  = FAC_W'(a);
    fac[R_GY]  = FAC_W'(b);
    fac[R_GZ]  = FAC_W'(e);
    fac[R_HXX] = FAC_W'(a * (a - 8'd1));
    fac[R_HYY] = FAC_W'(b * (b - 8'd1));
    fac[R_HZZ] = FAC_W'(e * (e - 8'd1));
    fac[R_HXY] = FAC_W'(a * b);
    fac[R_HXZ] = FAC_W'(a * e);
    fac[R_HYZ] = FAC_W'(b * e);
  end

  // Sums stay far inside 48 bits for 35 terms, so no clamp is needed
  always_ff @(posedge clk) begin
    for (int m = 0; m < N_OUT; m++) begin
      if (clear) begin
        acc_r[m] <= '0;
      end else if (s3_r.v) begin
        acc_r[m] <= acc_r[m] + acc_t'(t_r[m]) * $signed({1'b0, fac[m]});
      end
    end
  end

  assign acc  = acc_r;
  assign busy = s1_r.v | s2_r.v | s3_r.v;

endmodule

// ===== hw/rtl/tpe_checker.sv =====
module tpe_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [47:0]  out_value,
  input logic signed [47:0]  out_grad_x,
  input logic                out_write_error
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("result changed while stalled");

  // One item at a time: after a transfer the input closes
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // A flagged write carries no sums
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_error |-> out_value == 48'sd0 && out_grad_x == 48'sd0)
    else $error("write result carries sums");

endmodule

bind trivariate_poly_eval_grad_hess tpe_checker u_tpe_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tpe_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic mode;
    exp_t ex;
    exp_t ey;
    exp_t ez;
    q_t   coef;
    q_t   px;
    q_t   py;
    q_t   pz;
  } poly_item_t;

  typedef struct {
    acc_t sums [N_OUT];
    logic werr;
  } poly_res_t;

  // Bit-true model of the coefficient store and the evaluator; holds the
  // expected results in transfer order and checks the block against them.
  class poly_scoreboard;
    q_t        coefs [COEF_DEPTH];
    exp_t      tx [COEF_DEPTH];
    exp_t      ty [COEF_DEPTH];
    exp_t      tz [COEF_DEPTH];
    deg_t      degree;
    poly_res_t expected_q [$];
    int        mismatches;
    int        n_writes, n_rejected, n_evals, n_checked;

    function new();
      int idx;
      foreach (coefs[n]) coefs[n] = '0;
      degree = '0;
      for (int s = 0; s <= MAX_DEGREE; s++)
        for (int i = 0; i <= s; i++)
          for (int j = 0; j <= s - i; j++) begin
            idx = slot_of(i, j, s - i - j);
            tx[idx] = exp_t'(i);
            ty[idx] = exp_t'(j);
            tz[idx] = exp_t'(s - i - j);
          end
    endfunction

    // Number of terms of total degree up to d
    function int terms_upto(int d);
      return (d + 1) * (d + 2) * (d + 3) / 6;
    endfunction

    // Levels by degree, then z exponent, then y exponent
    function int slot_of(int i, int j, int k);
      int t;
      t = i + j;
      return terms_upto(i + j + k) - (t + 1) * (t + 2) / 2 + j;
    endfunction

    function int eff_degree();
      return (degree > MAX_DEGREE) ? MAX_DEGREE : int'(degree);
    endfunction

    // Q16.16 product: floor, then clamp to 32 bits
    function longint fxmul(longint a, longint b);
      longint p;
      p = (a * b) >>> 16;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p;
    endfunction

    function acc_t clamp48(longint v);
      longint lim;
      lim = longint'(1) <<< 47;
      if (v > lim - 1) v = lim - 1;
      if (v < -lim) v = -lim;
      return acc_t'(v);
    endfunction

    function void set_degree(deg_t d);
      degree = d;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Work out the result of an accepted input transfer
    function void note_input(poly_item_t it);
      poly_res_t r;
      longint xp [MAX_DEGREE+1];
      longint yp [MAX_DEGREE+1];
      longint zp [MAX_DEGREE+1];
      longint acc [N_OUT];
      longint c, a, b, e;
      int cnt;
      foreach (r.sums[m]) r.sums[m] = '0;
      r.werr = 1'b0;
      if (!it.mode) begin
        n_writes++;
        if (int'(it.ex) + int'(it.ey) + int'(it.ez) > eff_degree()) begin
          r.werr = 1'b1;
          n_rejected++;
        end else begin
          coefs[slot_of(it.ex, it.ey, it.ez)] = it.coef;
        end
        expected_q.push_back(r);
        return;
      end
      n_evals++;
      xp[0] = 65536; yp[0] = 65536; zp[0] = 65536;
      for (int p = 1; p <= MAX_DEGREE; p++) begin
        xp[p] = fxmul(xp[p-1], longint'(it.px));
        yp[p] = fxmul(yp[p-1], longint'(it.py));
        zp[p] = fxmul(zp[p-1], longint'(it.pz));
      end
      foreach (acc[m]) acc[m] = 0;
      cnt = terms_upto(eff_degree());
      for (int n = 0; n < cnt; n++) begin
        c = longint'(coefs[n]);
        a = tx[n]; b = ty[n]; e = tz[n];
        acc[R_VAL] += fxmul(fxmul(fxmul(c, xp[a]), yp[b]), zp[e]);
        if (a >= 1) acc[R_GX] += a * fxmul(fxmul(fxmul(c, xp[a-1]), yp[b]), zp[e]);
        if (b >= 1) acc[R_GY] += b * fxmul(fxmul(fxmul(c, xp[a]), yp[b-1]), zp[e]);
        if (e >= 1) acc[R_GZ] += e * fxmul(fxmul(fxmul(c, xp[a]), yp[b]), zp[e-1]);
        if (a >= 2)
          acc[R_HXX] += a * (a - 1) * fxmul(fxmul(fxmul(c, xp[a-2]), yp[b]), zp[e]);
        if (b >= 2)
          acc[R_HYY] += b * (b - 1) * fxmul(fxmul(fxmul(c, xp[a]), yp[b-2]), zp[e]);
        if (e >= 2)
          acc[R_HZZ] += e * (e - 1) * fxmul(fxmul(fxmul(c, xp[a]), yp[b]), zp[e-2]);
        if (a >= 1 && b >= 1)
          acc[R_HXY] += a * b * fxmul(fxmul(fxmul(c, xp[a-1]), yp[b-1]), zp[e]);
        if (a >= 1 && e >= 1)
          acc[R_HXZ] += a * e * fxmul(fxmul(fxmul(c, xp[a-1]), yp[b]), zp[e-1]);
        if (b >= 1 && e >= 1)
          acc[R_HYZ] += b * e * fxmul(fxmul(fxmul(c, xp[a]), yp[b-1]), zp[e-1]);
      end
      foreach (acc[m]) r.sums[m] = clamp48(acc[m]);
      expected_q.push_back(r);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH %s", what);
    endfunction

    // Compare an accepted result with the oldest expectation
    function void check_result(poly_res_t got);
      poly_res_t exp_r;
      string names [N_OUT] = '{"value", "grad_x", "grad_y", "grad_z", "hess_xx",
                               "hess_yy", "hess_zz", "hess_xy", "hess_xz", "hess_yz"};
      if (expected_q.size() == 0) begin
        flag("result with nothing expected");
        return;
      end
      exp_r = expected_q.pop_front();
      n_checked++;
      foreach (names[m])
        if (got.sums[m] !== exp_r.sums[m])
          flag($sformatf("result %0d %s: expected %0d, got %0d", n_checked, names[m],
                         exp_r.sums[m], got.sums[m]));
      if (got.werr !== exp_r.werr)
        flag($sformatf("result %0d write_error: expected %0b, got %0b", n_checked,
                       exp_r.werr, got.werr));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_poly_degree = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [2:0] in_exp_x = '0, in_exp_y = '0, in_exp_z = '0;
  logic signed [31:0] in_coef_value = '0, in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [47:0] out_value, out_grad_x, out_grad_y, out_grad_z;
  logic signed [47:0] out_hess_xx, out_hess_yy, out_hess_zz;
  logic signed [47:0] out_hess_xy, out_hess_xz, out_hess_yz;
  logic out_write_error;

  poly_scoreboard poly_sb = new();
  int  idle_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;
  int  stall_left = 0;

  always #2 clk = ~clk;

  trivariate_poly_eval_grad_hess i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_poly_degree(cfg_poly_degree),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_exp_x(in_exp_x), .in_exp_y(in_exp_y), .in_exp_z(in_exp_z),
    .in_coef_value(in_coef_value),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_grad_x(out_grad_x), .out_grad_y(out_grad_y),
    .out_grad_z(out_grad_z), .out_hess_xx(out_hess_xx), .out_hess_yy(out_hess_yy),
    .out_hess_zz(out_hess_zz), .out_hess_xy(out_hess_xy), .out_hess_xz(out_hess_xz),
    .out_hess_yz(out_hess_yz), .out_write_error(out_write_error)
  );

  // Monitor: sample every transfer at the rising edge and feed the
  // scoreboard; the watchdog counts edges with no transfer at all.
  always @(posedge clk) begin
    poly_item_t it;
    poly_res_t  res;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        res.sums = '{out_value, out_grad_x, out_grad_y, out_grad_z, out_hess_xx,
                     out_hess_yy, out_hess_zz, out_hess_xy, out_hess_xz, out_hess_yz};
        res.werr = out_write_error;
        poly_sb.check_result(res);
      end
      if (in_valid && in_ready) begin
        it = '{in_mode, in_exp_x, in_exp_y, in_exp_z, in_coef_value,
               in_point_x, in_point_y, in_point_z};
        poly_sb.note_input(it);
      end
      if (cfg_valid && cfg_ready) poly_sb.set_degree(cfg_poly_degree);
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

  // Receiver back-pressure: mostly short stalls, an occasional long one
  always @(negedge clk) begin
    int pick;
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        out_ready  <= 1'b1;
        stall_left <= $urandom_range(20, 1);
      end else if (pick < 95) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(3, 1);
      end else begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(60, 15);
      end
    end
  end

  // Hold valid and payload until the transfer, then return at the falling edge
  task automatic send(poly_item_t it);
    int gap;
    if (gaps_on) begin
      gap = $urandom_range(99);
      gap = (gap < 60) ? 0 : (gap < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_mode       <= it.mode;
    in_exp_x      <= it.ex;
    in_exp_y      <= it.ey;
    in_exp_z      <= it.ez;
    in_coef_value <= it.coef;
    in_point_x    <= it.px;
    in_point_y    <= it.py;
    in_point_z    <= it.pz;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (poly_sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Registers move only while the block is idle
  task automatic set_degree(deg_t d);
    drain();
    cfg_valid       <= 1'b1;
    cfg_poly_degree <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic poly_item_t filler();
    poly_item_t it;
    it.mode = 1'($urandom_range(1));
    it.ex = exp_t'($urandom); it.ey = exp_t'($urandom); it.ez = exp_t'($urandom);
    it.coef = q_t'($urandom); it.px = q_t'($urandom);
    it.py = q_t'($urandom); it.pz = q_t'($urandom);
    return it;
  endfunction

  task automatic put_coef(int i, int j, int k, q_t c);
    poly_item_t it;
    it = filler();
    it.mode = 1'b0; it.ex = exp_t'(i); it.ey = exp_t'(j); it.ez = exp_t'(k); it.coef = c;
    send(it);
  endtask

  task automatic eval_at(q_t x, q_t y, q_t z);
    poly_item_t it;
    it = filler();
    it.mode = 1'b1; it.px = x; it.py = y; it.pz = z;
    send(it);
  endtask

  // Small values in Q16.16 keep sums away from the rails most of the time
  function automatic q_t pick_q(int small_pct, int span);
    if ($urandom_range(99) < small_pct) return q_t'($urandom_range(2 * span) - span);
    return q_t'($urandom);
  endfunction

  // Random phase: mostly writes inside the degree and evaluations, the rest noise
  task automatic random_phase(int count, int deg);
    poly_item_t it;
    int pick, s;
    for (int n = 0; n < count; n++) begin
      it = filler();
      pick = $urandom_range(99);
      if (pick < 55) begin
        it.mode = 1'b0;
        s = $urandom_range(deg);
        it.ex = exp_t'($urandom_range(s));
        it.ey = exp_t'($urandom_range(s - int'(it.ex)));
        it.ez = exp_t'(s - int'(it.ex) - int'(it.ey));
        it.coef = pick_q(80, 8 << 16);
      end else if (pick < 85) begin
        it.mode = 1'b1;
        it.px = pick_q(85, 2 << 16);
        it.py = pick_q(85, 2 << 16);
        it.pz = pick_q(85, 2 << 16);
      end
      send(it);
    end
  endtask

  initial begin
    int deg_plan [8] = '{4, 1, 2, 3, 7, 0, 5, 4};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Degree zero after reset: only the constant term may be written
    put_coef(0, 0, 0, 32'sh7fffffff);
    put_coef(1, 0, 0, 32'sh00010000);
    eval_at(32'sh7fffffff, 32'sh80000000, 32'sh00000000);
    set_degree(deg_t'(4));
    put_coef(4, 0, 0, 32'sh80000000);
    put_coef(0, 4, 0, 32'sh7fffffff);
    put_coef(0, 0, 4, 32'sh00010000);
    put_coef(1, 1, 1, 32'shfffe0000);
    put_coef(2, 1, 1, 32'sh00030000);
    put_coef(1, 2, 0, 32'sh00008000);
    put_coef(0, 1, 3, 32'shffff0000);
    put_coef(7, 7, 7, 32'sh12345678);
    put_coef(3, 1, 1, 32'sh00010000);
    eval_at(32'sh00010000, 32'sh00010000, 32'sh00010000);
    eval_at(32'shffff0000, 32'sh00020000, 32'shffff8000);
    eval_at(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    eval_at(32'sh80000000, 32'sh80000000, 32'sh80000000);
    eval_at(32'sh00000000, 32'sh00000000, 32'sh00000000);
    eval_at(32'sh00000001, 32'shffffffff, 32'sh00018000);
    put_coef(0, 0, 0, 32'shffff0000);
    eval_at(32'sh00004000, 32'shffffc000, 32'sh00000000);

    // Random phases over several degree settings; one runs without idling on
    // either side and one more without receiver stalls
    foreach (deg_plan[p]) begin
      set_degree(deg_t'(deg_plan[p]));
      gaps_on   = (p != 3);
      stalls_on = (p != 3) && (p != 6);
      random_phase(90, (deg_plan[p] > MAX_DEGREE) ? MAX_DEGREE : deg_plan[p]);
    end

    in_valid <= 1'b0;
    while (poly_sb.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("covered %0d writes (%0d rejected) and %0d evaluations, %0d results checked",
             poly_sb.n_writes, poly_sb.n_rejected, poly_sb.n_evals, poly_sb.n_checked);
    $display("degree settings used: 0,1,2,3,4 and out-of-range 5,7; mismatches %0d",
             poly_sb.mismatches);
    if (poly_sb.mismatches == 0 && poly_sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tpe_pkg.sv
hw/rtl/tpe_coef_mem.sv
hw/rtl/tpe_pow_unit.sv
hw/rtl/tpe_term_pipe.sv
hw/rtl/trivariate_poly_eval_grad_hess.sv
hw/rtl/tpe_checker.sv
tb/sv/tb.sv
